/* rtl/core/dq_pkg.sv */
// Shared constants and types for the double-ended queue.
// Request and status codes, payload widths, memory access bundle.
// No dependencies.
`timescale 1ns / 1ps

package dq_pkg;

	localparam int DEPTH_DEF  = 16;
	localparam int DATA_W     = 32;
	localparam int COUNT_W    = 5;
	localparam int TYPE_W     = 3;
	localparam int STATUS_W   = 2;
	// widest slot address over the supported depth range (up to 4096)
	localparam int MAX_ADDR_W = 12;

	localparam logic [TYPE_W-1:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [TYPE_W-1:0] REQ_PUSH_REAR  = 3'd1;
	localparam logic [TYPE_W-1:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [TYPE_W-1:0] REQ_POP_REAR   = 3'd3;
	localparam logic [TYPE_W-1:0] REQ_QUERY      = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	localparam logic signed [DATA_W-1:0] EMPTY_MARK = -32'sd1;

	typedef struct packed {
		logic                  we;
		logic [MAX_ADDR_W-1:0] waddr;
		logic [DATA_W-1:0]     wdata;
		logic                  re;
		logic [MAX_ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage

/* rtl/core/dq_if.sv */
// Request and result channel interfaces for the double-ended queue.
// Valid/ready handshake with payload; depends on dq_pkg.
`timescale 1ns / 1ps

interface dq_req_if;
	logic                                  valid;
	logic                                  ready;
	logic [dq_pkg::TYPE_W-1:0]             req_type;
	logic signed [dq_pkg::DATA_W-1:0]      push_value;

	modport source (output valid, output req_type, output push_value, input ready);
	modport sink (input valid, input req_type, input push_value, output ready);
endinterface

interface dq_res_if;
	logic                                  valid;
	logic                                  ready;
	logic [dq_pkg::STATUS_W-1:0]           status;
	logic signed [dq_pkg::DATA_W-1:0]      removed_value;
	logic signed [dq_pkg::DATA_W-1:0]      front_value;
	logic signed [dq_pkg::DATA_W-1:0]      rear_value;
	logic [dq_pkg::COUNT_W-1:0]            count;

	modport source (output valid, output status, output removed_value,
		output front_value, output rear_value, output count, input ready);
	modport sink (input valid, input status, input removed_value,
		input front_value, input rear_value, input count, output ready);
endinterface

/* rtl/core/dq_mem.sv */
// Slot storage: one write port, one read port, registered read data.
// Depends on dq_pkg for the access bundle.
`timescale 1ns / 1ps

module dq_mem #(
	parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  dq_pkg::mem_req_t            mreq,
	output logic [dq_pkg::DATA_W-1:0]   rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [dq_pkg::DATA_W-1:0] mem [DEPTH];
	logic [dq_pkg::DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (mreq.we) begin
			mem[mreq.waddr[AW-1:0]] <= mreq.wdata;
		end
		if (mreq.re) begin
			rd_data_q <= mem[mreq.raddr[AW-1:0]];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/core/dq_ctrl.sv */
// Queue control: head/tail/count, cached end values, result register.
// Issues slot writes on push and one slot read on a pop that leaves a new end.
// Depends on dq_pkg, dq_if.
`timescale 1ns / 1ps

module dq_ctrl #(
	parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	dq_req_if.sink                      req,
	dq_res_if.source                    res,
	output dq_pkg::mem_req_t            mreq,
	input  logic [dq_pkg::DATA_W-1:0]   rd_data
);

	localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int MAW = dq_pkg::MAX_ADDR_W;
	localparam int DW  = dq_pkg::DATA_W;

	typedef enum logic {S_IDLE, S_READ} state_t;

	state_t                   state_q;
	logic [AW-1:0]            head_q, tail_q, head_n, tail_n;
	logic [CW-1:0]            cnt_q, cnt_n;
	logic signed [DW-1:0]     front_q, rear_q, front_n, rear_n;
	logic                     pop_front_q;
	logic                     out_valid_q;
	logic [dq_pkg::STATUS_W-1:0] status_q, status_n;
	logic signed [DW-1:0]     removed_q, removed_n;
	logic signed [DW-1:0]     front_out_q, rear_out_q;
	logic [dq_pkg::COUNT_W-1:0] count_q;
	logic                     accept, go_read, empty, full;

	function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
		return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
	endfunction

	function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
		return (i == '0) ? AW'(DEPTH - 1) : i - AW'(1);
	endfunction

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE) && (!out_valid_q || res.ready);
	assign empty     = (cnt_q == '0);
	assign full      = (cnt_q == CW'(DEPTH));

	always_comb begin
		head_n    = head_q;
		tail_n    = tail_q;
		cnt_n     = cnt_q;
		front_n   = front_q;
		rear_n    = rear_q;
		status_n  = dq_pkg::ST_OK;
		removed_n = '0;
		go_read   = 1'b0;
		mreq      = '0;
		if (accept) begin
			unique case (req.req_type)
				dq_pkg::REQ_PUSH_FRONT: begin
					if (full) begin
						status_n = dq_pkg::ST_FULL;
					end else begin
						head_n     = idx_dec(head_q);
						cnt_n      = cnt_q + CW'(1);
						front_n    = req.push_value;
						rear_n     = empty ? req.push_value : rear_q;
						mreq.we    = 1'b1;
						mreq.waddr = MAW'(head_n);
						mreq.wdata = req.push_value;
					end
				end
				dq_pkg::REQ_PUSH_REAR: begin
					if (full) begin
						status_n = dq_pkg::ST_FULL;
					end else begin
						tail_n     = idx_inc(tail_q);
						cnt_n      = cnt_q + CW'(1);
						rear_n     = req.push_value;
						front_n    = empty ? req.push_value : front_q;
						mreq.we    = 1'b1;
						mreq.waddr = MAW'(tail_q);
						mreq.wdata = req.push_value;
					end
				end
				dq_pkg::REQ_POP_FRONT: begin
					if (empty) begin
						status_n = dq_pkg::ST_EMPTY;
					end else begin
						removed_n  = front_q;
						head_n     = idx_inc(head_q);
						cnt_n      = cnt_q - CW'(1);
						// fetch the new front unless the queue drains
						go_read    = (cnt_q != CW'(1));
						mreq.re    = go_read;
						mreq.raddr = MAW'(head_n);
					end
				end
				dq_pkg::REQ_POP_REAR: begin
					if (empty) begin
						status_n = dq_pkg::ST_EMPTY;
					end else begin
						removed_n  = rear_q;
						tail_n     = idx_dec(tail_q);
						cnt_n      = cnt_q - CW'(1);
						go_read    = (cnt_q != CW'(1));
						mreq.re    = go_read;
						mreq.raddr = MAW'(idx_dec(tail_n));
					end
				end
				default: begin
					status_n = dq_pkg::ST_OK;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			front_q     <= '0;
			rear_q      <= '0;
			pop_front_q <= 1'b0;
			out_valid_q <= 1'b0;
			status_q    <= dq_pkg::ST_OK;
			removed_q   <= '0;
			front_out_q <= '0;
			rear_out_q  <= '0;
			count_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						head_q      <= head_n;
						tail_q      <= tail_n;
						cnt_q       <= cnt_n;
						front_q     <= front_n;
						rear_q      <= rear_n;
						status_q    <= status_n;
						removed_q   <= removed_n;
						count_q     <= dq_pkg::COUNT_W'(cnt_n);
						pop_front_q <= (req.req_type == dq_pkg::REQ_POP_FRONT);
						if (go_read) begin
							// hold the result until the new end slot returns
							state_q     <= S_READ;
							out_valid_q <= 1'b0;
						end else begin
							out_valid_q <= 1'b1;
							front_out_q <= (cnt_n == '0) ? dq_pkg::EMPTY_MARK : front_n;
							rear_out_q  <= (cnt_n == '0) ? dq_pkg::EMPTY_MARK : rear_n;
						end
					end else if (res.ready) begin
						// drop the result once it is taken
						out_valid_q <= 1'b0;
					end
				end
				S_READ: begin
					state_q     <= S_IDLE;
					out_valid_q <= 1'b1;
					if (pop_front_q) begin
						front_q     <= rd_data;
						front_out_q <= rd_data;
						rear_out_q  <= rear_q;
					end else begin
						rear_q      <= rd_data;
						rear_out_q  <= rd_data;
						front_out_q <= front_q;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res.valid         = out_valid_q;
	assign res.status        = status_q;
	assign res.removed_value = removed_q;
	assign res.front_value   = front_out_q;
	assign res.rear_value    = rear_out_q;
	assign res.count         = count_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("element count above depth");

	a_ptr_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(head_q) + int'(cnt_q) == int'(tail_q))
		|| (int'(head_q) + int'(cnt_q) == int'(tail_q) + DEPTH))
		else $error("head, tail and count disagree");

	a_read_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |-> !req.ready && !res.valid)
		else $error("request taken or result shown during slot read");

	a_pop_reads: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.req_type == dq_pkg::REQ_POP_FRONT
			|| req.req_type == dq_pkg::REQ_POP_REAR) && cnt_q > CW'(1)
		|=> state_q == S_READ)
		else $error("pop leaving elements did not fetch new end");

	a_write_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		!(mreq.we && mreq.re))
		else $error("slot write and read issued together");

endmodule

/* rtl/core/double_ended_queue.sv */
// Double-ended queue of signed 32-bit values in a ring of DEPTH slots.
// Result registered after the request, except a pop that leaves the queue
// non-empty: it first passes through S_READ for one slot-memory read of the new end.
// Throughput: 1 request per cycle while results are taken; such pops stall in S_READ.
// Reset: pointers, count, cached ends and result register clear; slots are not cleared.
`timescale 1ns / 1ps

module double_ended_queue #(
	parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	dq_req_if.sink   req,
	dq_res_if.source res
);

	dq_pkg::mem_req_t              mreq;
	logic [dq_pkg::DATA_W-1:0]     rd_data;

	dq_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.res     (res),
		.mreq    (mreq),
		.rd_data (rd_data)
	);

	dq_mem #(
		.DEPTH (DEPTH)
	) u_mem (
		.clk     (clk),
		.mreq    (mreq),
		.rd_data (rd_data)
	);

endmodule
